// ===== rtl/fifo_page_tag_cache_defines.svh =====
// Assertion macros used by the page tag cache RTL
`ifndef FIFO_PAGE_TAG_CACHE_DEFINES_SVH
`define FIFO_PAGE_TAG_CACHE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/fptc_pkg.sv =====
// Types and constants of the page tag cache
package fptc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int PAGE_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int LIMIT_W = 4;
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd15;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PAGE_W-1:0] page_t;

  typedef struct packed {
    logic hit;
    idx_t idx;
  } match_t;

  typedef struct packed {
    idx_t oldest;
    cnt_t count;
  } ring_t;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

endpackage

// ===== rtl/fifo_page_tag_cache.sv =====
// Top level: FIFO-replacement page tag cache built from a row of tag cells
// A page taken in S_IDLE is registered; lookup and ring update share the S_LOOKUP cycle, which
// registers out_tvalid; a waiting result stalls the lookup. No new item enters until it is done.
// The result register lets the next item enter while a result waits downstream.
// Reset (synchronous, rst_n low): ring empty, oldest slot 0, cache_limit 15.
// Tag storage is not cleared; only held slots are ever compared or read.
`include "fifo_page_tag_cache_defines.svh"

module fifo_page_tag_cache (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [fptc_pkg::LIMIT_W-1:0]      cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fptc_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] page_number
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fptc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [3:0] slot, [4] evicted, [36:5] evicted_page
  output logic                              out_tuser   // [0] hit
);
  import fptc_pkg::*;

  state_t               state_r, state_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  page_t                req_r;
  idx_t                 oldest_r, oldest_nxt;
  cnt_t                 count_r, count_nxt;
  logic                 out_tvalid_r;
  logic                 out_hit_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_ev_r;
  page_t                out_ev_page_r;

  ring_t                ring;
  match_t               chain [ENTRIES+1];
  page_t                tag_rd [ENTRIES];
  logic [ENTRIES-1:0]   wr_sel;

  logic                 hit_any;
  logic                 do_evict;
  logic                 done;
  idx_t                 oldest_ev;
  cnt_t                 count_ev;
  logic [IDX_W:0]       ins_sum;
  idx_t                 ins;

  assign ring.oldest = oldest_r;
  assign ring.count  = count_r;
  assign chain[0]    = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    fptc_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(g)),
      .ring      (ring),
      .cmp_page  (req_r),
      .wr_en     (wr_sel[g]),
      .wr_page   (req_r),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .tag       (tag_rd[g])
    );
    assign wr_sel[g] = done && !hit_any && (ins == IDX_W'(g));
  end

  always_comb begin
    hit_any  = chain[ENTRIES].hit;
    do_evict = (count_r != '0) &&
               ((CMP_W'(count_r) > CMP_W'(limit_r)) || (count_r >= CNT_W'(ENTRIES)));
    count_ev = count_r - CNT_W'(do_evict);
    if (!do_evict) begin
      oldest_ev = oldest_r;
    end else if (oldest_r == IDX_W'(ENTRIES - 1)) begin
      oldest_ev = '0;
    end else begin
      oldest_ev = oldest_r + 1'b1;
    end
    ins_sum = (IDX_W+1)'(oldest_ev) + (IDX_W+1)'(count_ev);
    if (ins_sum >= (IDX_W+1)'(ENTRIES)) begin
      ins = IDX_W'(ins_sum - (IDX_W+1)'(ENTRIES));
    end else begin
      ins = ins_sum[IDX_W-1:0];
    end

    done       = (state_r == S_LOOKUP) && (!out_tvalid_r || out_tready);
    in_tready  = (state_r == S_IDLE);
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (done) begin
          state_nxt = S_IDLE;
          if (!hit_any) begin
            oldest_nxt = oldest_ev;
            count_nxt  = count_ev + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      limit_r      <= LIMIT_RST;
      oldest_r     <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (done) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= in_tdata[PAGE_W-1:0];
    end
    if (done) begin
      out_hit_r     <= hit_any;
      out_slot_r    <= hit_any ? SLOT_W'(chain[ENTRIES].idx) : SLOT_W'(ins);
      out_ev_r      <= !hit_any && do_evict;
      out_ev_page_r <= (!hit_any && do_evict) ? tag_rd[oldest_r] : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = OUT_TDATA_W'({out_ev_page_r, out_ev_r, out_slot_r});

  `ASSERT_NEVER(a_count_max, count_r > CNT_W'(ENTRIES), "held count exceeds ring size")
  `ASSERT_CLK(a_hit_no_evict, out_tvalid && out_tuser |-> !out_ev_r && (out_ev_page_r == '0), "hit result reports an eviction")
  `ASSERT_CLK(a_hit_stable, done && hit_any |=> $stable(oldest_r) && $stable(count_r), "hit changed ring state")
  `ASSERT_CLK(a_miss_holds, done && !hit_any |=> count_r != '0, "miss left ring empty")

endmodule

// ===== rtl/fptc_cell.sv =====
// One tag cell: holds a slot's tag, compares it and passes the match along the row
module fptc_cell (
  input  logic                         clk,
  input  logic [fptc_pkg::IDX_W-1:0]   cell_idx,
  input  fptc_pkg::ring_t              ring,
  input  fptc_pkg::page_t              cmp_page,
  input  logic                         wr_en,
  input  fptc_pkg::page_t              wr_page,
  input  fptc_pkg::match_t             chain_in,
  output fptc_pkg::match_t             chain_out,
  output fptc_pkg::page_t              tag
);
  import fptc_pkg::*;

  page_t             tag_r;
  logic [IDX_W:0]    wrap_sum;
  idx_t              off;
  logic              held;
  logic              match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_r <= wr_page;
    end
  end

  always_comb begin
    wrap_sum = {1'b0, cell_idx} + (IDX_W+1)'(ENTRIES) - {1'b0, ring.oldest};
    if (cell_idx >= ring.oldest) begin
      off = cell_idx - ring.oldest;
    end else begin
      off = wrap_sum[IDX_W-1:0];
    end
    held  = CNT_W'(off) < ring.count;
    match = held && (tag_r == cmp_page);
    chain_out.hit = chain_in.hit | match;
    chain_out.idx = match ? cell_idx : chain_in.idx;
  end

  assign tag = tag_r;

endmodule

// ===== test/fifo_page_tag_cache_test.sv =====
// Self-checking stimulus and lookup checker for the FIFO page tag cache
module fifo_page_tag_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fptc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 165;
  localparam int POOL_SIZE = 32;
  localparam int PEND_DEPTH = 8;
  localparam int DIR_MAX = 32;

  typedef struct packed {
    logic  hit;
    idx_t  slot;
    logic  evicted;
    page_t evicted_page;
  } lookup_t;

  typedef struct packed {
    logic                     set_limit;
    logic [LIMIT_W-1:0]       limit;
    page_t                    page;
    logic                     typed;
    lookup_t                  want;
  } stim_row_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_LONG_STALL
  } ready_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]     cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;  // [31:0] page_number
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // [3:0] slot, [4] evicted, [36:5] evicted_page
  logic                   out_tuser;      // [0] hit

  page_t              tag_ring [ENTRIES];
  idx_t               ring_oldest = '0;
  cnt_t               ring_count = '0;
  logic [LIMIT_W-1:0] limit_reg = LIMIT_RST;

  lookup_t     pending [PEND_DEPTH];
  int          pend_wr = 0;
  int          pend_rd = 0;
  stim_row_t   dir_rows [DIR_MAX];
  int          dir_count = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  ready_mode_t ready_mode = READY_RANDOM;
  logic [7:0]  ready_phase = '0;

  fifo_page_tag_cache DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic lookup_t lookup_page(page_t page);
    lookup_t res;
    idx_t    s;
    res = '0;
    for (int i = 0; i < ring_count; i++) begin
      s = idx_t'((ring_oldest + i) % ENTRIES);
      if (tag_ring[s] == page) begin
        res.hit = 1'b1;
        res.slot = s;
        return res;
      end
    end
    if (ring_count > 0 && (ring_count > limit_reg || ring_count >= ENTRIES)) begin
      res.evicted = 1'b1;
      res.evicted_page = tag_ring[ring_oldest];
      ring_oldest = idx_t'((ring_oldest + 1) % ENTRIES);
      ring_count = ring_count - 1'b1;
    end
    res.slot = idx_t'((ring_oldest + ring_count) % ENTRIES);
    tag_ring[res.slot] = page;
    ring_count = ring_count + 1'b1;
    return res;
  endfunction

  function automatic stim_row_t row(logic set_limit, logic [LIMIT_W-1:0] limit, page_t page,
                                    logic typed, logic hit, idx_t slot, logic evicted,
                                    page_t evicted_page);
    stim_row_t r;
    r.set_limit = set_limit;
    r.limit = limit;
    r.page = page;
    r.typed = typed;
    r.want.hit = hit;
    r.want.slot = slot;
    r.want.evicted = evicted;
    r.want.evicted_page = evicted_page;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows[dir_count] = r;
    dir_count++;
  endfunction

  // raise valid and hold until the item is taken; a typed row overrides the prediction
  task automatic send_page(page_t page, logic typed, lookup_t want);
    lookup_t predicted;
    in_tvalid <= 1'b1;
    in_tdata <= page;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = lookup_page(page);
    pending[pend_wr % PEND_DEPTH] = typed ? want : predicted;
    pend_wr++;
  endtask

  task automatic pause_sender(int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain outstanding items before touching the limit register
  task automatic set_limit(logic [LIMIT_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value;
  endtask

  always @(posedge clk) begin
    ready_phase <= ready_phase + 1'b1;
    case (ready_mode)
      READY_ALWAYS: begin
        out_tready <= 1'b1;
      end
      READY_RANDOM: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      READY_PERIODIC: begin
        out_tready <= (ready_phase % 7) < 4;
      end
      default: begin
        out_tready <= ready_phase[5:4] != 2'b11;
      end
    endcase
  end

  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit = out_tuser;
      got.slot = out_tdata[3:0];
      got.evicted = out_tdata[4];
      got.evicted_page = out_tdata[36:5];
      if (pend_wr == pend_rd) begin
        $error("unexpected result: page slot %0d hit %0d", got.slot, got.hit);
        errors++;
      end else begin
        want = pending[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, got.hit);
          errors++;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, got.slot);
          errors++;
        end
        if (got.evicted !== want.evicted) begin
          $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
          errors++;
        end
        if (got.evicted_page !== want.evicted_page) begin
          $error("evicted_page: expected %h, actual %h", want.evicted_page, got.evicted_page);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("fifo_page_tag_cache verification failed");
      $finish;
    end
  end

  initial begin
    page_t       pool [POOL_SIZE];
    page_t       page;
    logic [LIMIT_W-1:0] phase_limits [10];
    int          burst_left;
    int          pick;
    logic        bursty;

    add_row(row(1, 0, 0, 0, 0, 0, 0, 0));
    add_row(row(0, 0, 32'h0000_0007, 1, 0, 0, 0, 0));
    add_row(row(0, 0, 32'h0000_0007, 1, 1, 0, 0, 0));
    add_row(row(0, 0, 32'h0000_0000, 1, 0, 1, 1, 32'h0000_0007));
    add_row(row(0, 0, 32'h0000_0000, 1, 1, 1, 0, 0));
    add_row(row(1, 15, 0, 0, 0, 0, 0, 0));
    add_row(row(0, 0, 32'hFFFF_FFFF, 1, 0, 2, 0, 0));
    for (int k = 1; k <= 14; k++) begin
      add_row(row(0, 0, page_t'(k) | (page_t'(k) << 20), 0, 0, 0, 0, 0));
    end
    // ring full: the oldest tag goes to make room for the new page
    add_row(row(0, 0, 32'hAAAA_AAAA, 1, 0, 1, 1, 32'h0000_0000));
    add_row(row(0, 0, 32'hFFFF_FFFF, 1, 1, 2, 0, 0));
    // lower the limit while the ring is full
    add_row(row(1, 3, 0, 0, 0, 0, 0, 0));
    add_row(row(0, 0, 32'h5555_5555, 0, 0, 0, 0, 0));
    add_row(row(0, 0, 32'h8000_0000, 0, 0, 0, 0, 0));
    add_row(row(0, 0, 32'h5555_5555, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < dir_count; r++) begin
      if (dir_rows[r].set_limit) begin
        set_limit(dir_rows[r].limit);
      end else begin
        send_page(dir_rows[r].page, dir_rows[r].typed, dir_rows[r].want);
        pause_sender($urandom_range(0, 2));
      end
    end

    phase_limits = '{4'd0, 4'd15, 4'd1, 4'd14, 4'd7, 4'd0, 4'd2, 4'd15,
                     LIMIT_W'($urandom_range(0, 15)), LIMIT_W'($urandom_range(0, 15))};
    foreach (pool[k]) pool[k] = $urandom;

    foreach (phase_limits[ph]) begin
      set_limit(phase_limits[ph]);
      ready_mode = ready_mode_t'(ph % 4);
      bursty = (ph % 3) != 1;
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40 && ring_count > 0) begin
          page = tag_ring[(ring_oldest + $urandom_range(0, ring_count - 1)) % ENTRIES];
        end else if (pick < 85) begin
          page = pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          page = $urandom;
        end
        if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        send_page(page, 1'b0, '0);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (bursty) pause_sender($urandom_range(1, 6));
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("fifo_page_tag_cache verification clean");
    end else begin
      $display("fifo_page_tag_cache verification failed");
    end
    $finish;
  end

endmodule
